@@ rtl/core/oledfb_pkg.sv @@
// ----------------------------------------------------------------------------
// oledfb_pkg
// Types and constants shared by the OLED frame store blocks.
// ----------------------------------------------------------------------------
package oledfb_pkg;

	localparam logic [1:0] ACT_POINT   = 2'd0;
	localparam logic [1:0] ACT_FILL    = 2'd1;
	localparam logic [1:0] ACT_REFRESH = 2'd2;

	localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
	localparam logic [7:0] CMD_COL_LOW   = 8'h00;
	localparam logic [7:0] CMD_COL_HIGH  = 8'h10;

	localparam int CMD_SLOT_COUNT = 3;
	localparam int PAGE_ROWS      = 8;
	localparam int QUEUE_DEPTH    = 4;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] x_start;
		logic [7:0] y_start;
		logic [7:0] x_end;
		logic [7:0] y_end;
		logic       pixel_value;
	} cmd_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_data;
		logic       last;
	} rsp_item_t;

	typedef enum logic {
		OP_FILL,
		OP_REFRESH
	} op_kind_t;

	typedef struct packed {
		op_kind_t   kind;
		logic [7:0] x_lo;
		logic [7:0] x_hi;
		logic [7:0] y_lo;
		logic [7:0] y_hi;
		logic       value;
	} op_entry_t;

endpackage

@@ rtl/core/oledfb_front.sv @@
// ----------------------------------------------------------------------------
// oledfb_front
// Accepts command items, drops those with no effect, turns points and fills
// into clipped rectangle operations and passes refreshes to the operation queue.
// ----------------------------------------------------------------------------
module oledfb_front #(
	parameter int SCREEN_WIDTH = 128,
	parameter int PAGE_COUNT   = 8
) (
	input  logic                  cmd_valid,
	output logic                  cmd_ready,
	input  oledfb_pkg::cmd_item_t cmd,
	input  logic                  queue_full,
	input  logic                  clearing,
	output logic                  push,
	output oledfb_pkg::op_entry_t entry
);
	import oledfb_pkg::*;

	localparam logic [7:0] XMax = 8'(SCREEN_WIDTH - 1);
	localparam logic [7:0] YMax = 8'(PAGE_COUNT * PAGE_ROWS - 1);

	logic       is_point;
	logic       is_draw;
	logic       is_refresh;
	logic [7:0] x_end_raw;
	logic [7:0] y_end_raw;
	logic       draw_ok;

	always_comb begin
		is_point   = (cmd.action == ACT_POINT);
		is_draw    = cmd.action inside {ACT_POINT, ACT_FILL};
		is_refresh = (cmd.action == ACT_REFRESH);
		x_end_raw  = is_point ? cmd.x_start : cmd.x_end;
		y_end_raw  = is_point ? cmd.y_start : cmd.y_end;
		draw_ok    = is_draw && (cmd.x_start <= x_end_raw) && (cmd.y_start <= y_end_raw)
			&& (cmd.x_start <= XMax) && (cmd.y_start <= YMax);
		entry.kind  = is_refresh ? OP_REFRESH : OP_FILL;
		entry.x_lo  = cmd.x_start;
		entry.y_lo  = cmd.y_start;
		entry.x_hi  = (x_end_raw > XMax) ? XMax : x_end_raw;
		entry.y_hi  = (y_end_raw > YMax) ? YMax : y_end_raw;
		entry.value = cmd.pixel_value;
	end

	assign cmd_ready = !queue_full && !clearing;
	assign push      = cmd_valid && cmd_ready && (draw_ok || is_refresh);

endmodule

@@ rtl/core/oledfb_fifo.sv @@
// ----------------------------------------------------------------------------
// oledfb_fifo
// Short first-in first-out queue of operations between front and back.
// ----------------------------------------------------------------------------
module oledfb_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  oledfb_pkg::op_entry_t push_entry,
	input  logic                  pop,
	output oledfb_pkg::op_entry_t head,
	output logic                  empty,
	output logic                  full
);
	import oledfb_pkg::*;

	localparam int PtrW = $clog2(QUEUE_DEPTH);
	localparam int CntW = $clog2(QUEUE_DEPTH + 1);

	op_entry_t       slots_q [QUEUE_DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == CntW'(QUEUE_DEPTH));
	assign head  = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= PtrW'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= PtrW'(rd_ptr_q + 1'b1);
			end
			if (push && !pop) begin
				count_q <= CntW'(count_q + 1'b1);
			end else if (pop && !push) begin
				count_q <= CntW'(count_q - 1'b1);
			end
		end
	end

endmodule

@@ rtl/core/oledfb_back.sv @@
// ----------------------------------------------------------------------------
// oledfb_back
// Owns the frame store. Clears it after reset, walks rectangle operations
// byte by byte with read-modify-write, and produces the refresh stream.
// ----------------------------------------------------------------------------
module oledfb_back #(
	parameter int SCREEN_WIDTH = 128,
	parameter int PAGE_COUNT   = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  oledfb_pkg::op_entry_t head,
	input  logic                  q_empty,
	output logic                  pop,
	output logic                  clearing,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output oledfb_pkg::rsp_item_t rsp
);
	import oledfb_pkg::*;

	localparam int XW     = $clog2(SCREEN_WIDTH);
	localparam int PW     = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
	localparam int AW     = XW + PW;
	localparam int MemDepth = 1 << AW;
	localparam int SW     = $clog2(SCREEN_WIDTH + CMD_SLOT_COUNT);
	localparam logic [SW-1:0] LastSlot = SW'(SCREEN_WIDTH + CMD_SLOT_COUNT - 1);
	localparam logic [PW-1:0] LastPage = PW'(PAGE_COUNT - 1);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FILL_RD,
		ST_FILL_WR,
		ST_REF_WR
	} state_t;

	state_t          state_q;
	logic [AW-1:0]   clr_q;
	logic [SW-1:0]   slot_q;
	logic [PW-1:0]   page_q;
	logic            out_valid_q;
	rsp_item_t       out_q;

	logic [7:0]      x_q;
	logic [7:0]      x_hi_q;
	logic [PW-1:0]   b_q;
	logic [PW-1:0]   b_lo_q;
	logic [PW-1:0]   b_hi_q;
	logic [2:0]      y_lo_q;
	logic [2:0]      y_hi_q;
	logic            val_q;

	logic [7:0]      mem [MemDepth];
	logic [7:0]      rdata_q;

	logic            rd_en;
	logic [AW-1:0]   rd_addr;
	logic            wr_en;
	logic [AW-1:0]   wr_addr;
	logic [7:0]      wr_data;
	logic            out_load;
	logic            out_free;
	rsp_item_t       out_next;

	logic [2:0]      lo;
	logic [2:0]      hi;
	logic [7:0]      mask;
	logic [7:0]      merged;
	logic [AW-1:0]   fill_addr;
	logic [AW-1:0]   ref_addr;
	logic            is_cmd_slot;
	logic [7:0]      cmd_byte;
	logic            ref_last;

	assign out_free  = !out_valid_q || rsp_ready;
	assign clearing  = (state_q == ST_CLEAR);
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	always_comb begin
		lo = (b_q == b_lo_q) ? y_lo_q : 3'd0;
		hi = (b_q == b_hi_q) ? y_hi_q : 3'd7;
		for (int i = 0; i < 8; i++) begin
			mask[7 - i] = (3'(i) >= lo) && (3'(i) <= hi);
		end
		merged    = val_q ? (rdata_q | mask) : (rdata_q & ~mask);
		fill_addr = {x_q[XW-1:0], PW'(LastPage - b_q)};
		ref_addr  = {XW'(slot_q - SW'(CMD_SLOT_COUNT)), page_q};
		is_cmd_slot = (slot_q < SW'(CMD_SLOT_COUNT));
		if (slot_q == SW'(0)) begin
			cmd_byte = 8'(CMD_PAGE_BASE + 8'(page_q));
		end else if (slot_q == SW'(1)) begin
			cmd_byte = CMD_COL_LOW;
		end else begin
			cmd_byte = CMD_COL_HIGH;
		end
		ref_last = (page_q == LastPage) && (slot_q == LastSlot);
		out_next.out_byte = (state_q == ST_REF_WR) ? rdata_q : cmd_byte;
		out_next.is_data  = (state_q == ST_REF_WR);
		out_next.last     = (state_q == ST_REF_WR) && ref_last;
	end

	always_comb begin
		pop      = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = fill_addr;
		wr_en    = 1'b0;
		wr_addr  = fill_addr;
		wr_data  = merged;
		out_load = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = '0;
			end
			ST_IDLE: begin
				if (!q_empty) begin
					if (head.kind == OP_FILL) begin
						pop = 1'b1;
					end else if (!is_cmd_slot) begin
						pop     = 1'b1;
						rd_en   = 1'b1;
						rd_addr = ref_addr;
					end else if (out_free) begin
						pop      = 1'b1;
						out_load = 1'b1;
					end
				end
			end
			ST_FILL_RD: begin
				rd_en = 1'b1;
			end
			ST_FILL_WR: begin
				wr_en = 1'b1;
			end
			ST_REF_WR: begin
				out_load = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			slot_q      <= '0;
			page_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
				out_q       <= out_next;
				if (slot_q == LastSlot) begin
					slot_q <= '0;
					page_q <= (page_q == LastPage) ? '0 : PW'(page_q + 1'b1);
				end else begin
					slot_q <= SW'(slot_q + 1'b1);
				end
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= AW'(clr_q + 1'b1);
					if (clr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (pop) begin
						if (head.kind == OP_FILL) begin
							x_q     <= head.x_lo;
							x_hi_q  <= head.x_hi;
							b_q     <= PW'(head.y_lo >> 3);
							b_lo_q  <= PW'(head.y_lo >> 3);
							b_hi_q  <= PW'(head.y_hi >> 3);
							y_lo_q  <= head.y_lo[2:0];
							y_hi_q  <= head.y_hi[2:0];
							val_q   <= head.value;
							state_q <= ST_FILL_RD;
						end else if (!is_cmd_slot) begin
							state_q <= ST_REF_WR;
						end
					end
				end
				ST_FILL_RD: begin
					state_q <= ST_FILL_WR;
				end
				ST_FILL_WR: begin
					if (b_q == b_hi_q) begin
						if (x_q == x_hi_q) begin
							state_q <= ST_IDLE;
						end else begin
							x_q     <= 8'(x_q + 1'b1);
							b_q     <= b_lo_q;
							state_q <= ST_FILL_RD;
						end
					end else begin
						b_q     <= PW'(b_q + 1'b1);
						state_q <= ST_FILL_RD;
					end
				end
				ST_REF_WR: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_empty)
		else $error("Operation taken from an empty queue.");

	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> (!pop && !out_valid_q))
		else $error("Activity during the clearing pass.");

	a_stream_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(slot_q <= LastSlot) && (page_q <= LastPage))
		else $error("Refresh position out of range.");

	a_fill_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FILL_RD) |-> ((x_q <= x_hi_q) && (b_q <= b_hi_q) && (b_lo_q <= b_q)))
		else $error("Fill walker outside its rectangle.");

	a_last_is_data: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.last) |-> out_q.is_data)
		else $error("Final stream item is not a data byte.");

endmodule

@@ rtl/core/oled_framebuffer_draw_fill_refresh_top.sv @@
// ----------------------------------------------------------------------------
// oled_framebuffer_draw_fill_refresh_top
// Monochrome OLED frame store with point draw, rectangle fill and a
// byte-serial page refresh stream.
//
//   Channel  Signals                       Carries
//   cmd      cmd_valid, cmd_ready, cmd     draw point, fill or refresh request
//   rsp      rsp_valid, rsp_ready, rsp     one refresh stream byte
//
// A point or fill leaves the queue, then reads and writes back each frame
// byte it touches (columns times pages spanned) in ST_FILL_RD and ST_FILL_WR.
// A refresh command byte goes straight into the result register; a refresh
// data byte first passes through the registered read of the frame store.
// After reset the frame store, 2**ceil(log2(SCREEN_WIDTH)) times
// 2**max(1, ceil(log2(PAGE_COUNT))) bytes (1024 by default), is cleared one
// byte a cycle, during which cmd_ready stays low.
// A four-entry operation queue lets commands be taken while the back end is
// busy or the result register waits on rsp_ready.
// ----------------------------------------------------------------------------
module oled_framebuffer_draw_fill_refresh_top #(
	parameter int SCREEN_WIDTH = 128,
	parameter int PAGE_COUNT   = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_ready,
	input  oledfb_pkg::cmd_item_t cmd,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output oledfb_pkg::rsp_item_t rsp
);
	import oledfb_pkg::*;

	logic      push;
	op_entry_t push_entry;
	op_entry_t head;
	logic      q_empty;
	logic      q_full;
	logic      pop;
	logic      clearing;

	oledfb_front #(
		.SCREEN_WIDTH (SCREEN_WIDTH),
		.PAGE_COUNT   (PAGE_COUNT)
	) u_front (
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.cmd        (cmd),
		.queue_full (q_full),
		.clearing   (clearing),
		.push       (push),
		.entry      (push_entry)
	);

	oledfb_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.empty      (q_empty),
		.full       (q_full)
	);

	oledfb_back #(
		.SCREEN_WIDTH (SCREEN_WIDTH),
		.PAGE_COUNT   (PAGE_COUNT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_empty   (q_empty),
		.pop       (pop),
		.clearing  (clearing),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the OLED frame store against a predictor of its frame, its point
// draws, its rectangle fills and its page-by-page refresh stream. The test
// covers edge cases, a run of two stream pages' worth of refreshes, and random
// traffic under three settings of sender and receiver stalls, the last with none.
// ----------------------------------------------------------------------------
module testbench;

	import oledfb_pkg::*;

	localparam int SCREEN_W = 128;
	localparam int PAGES = 8;
	localparam int ROWS = PAGES * PAGE_ROWS;
	localparam int PAGE_STREAM_LEN = CMD_SLOT_COUNT + SCREEN_W;
	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 50000;
	localparam int DRAIN_CYCLES = 9000;

	logic clk = 1'b0;
	logic arst_n;
	logic cmd_valid;
	logic cmd_ready;
	cmd_item_t cmd;
	logic rsp_valid;
	logic rsp_ready;
	rsp_item_t rsp;

	bit [7:0] frame_bytes [SCREEN_W * PAGES];
	int unsigned stream_page;
	int unsigned stream_slot;
	rsp_item_t refresh_bytes_due [$];
	int mismatch_count;
	int quiet_cycles;
	int send_idle_pct;
	int recv_idle_pct;

	oled_framebuffer_draw_fill_refresh_top #(
		.SCREEN_WIDTH(SCREEN_W),
		.PAGE_COUNT(PAGES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic void plot_pixel(int unsigned x, int unsigned y, bit on);
		int unsigned idx;
		bit [7:0] mask;
		if (x > SCREEN_W - 1 || y > ROWS - 1)
			return;
		idx = x * PAGES + (PAGES - 1 - y / PAGE_ROWS);
		mask = 8'h80 >> (y % PAGE_ROWS);
		if (on)
			frame_bytes[idx] = frame_bytes[idx] | mask;
		else
			frame_bytes[idx] = frame_bytes[idx] & ~mask;
	endfunction

	function automatic void fill_area(int unsigned x1, int unsigned y1, int unsigned x2,
			int unsigned y2, bit on);
		if (x1 > x2 || y1 > y2)
			return;
		if (x2 > SCREEN_W - 1)
			x2 = SCREEN_W - 1;
		if (y2 > ROWS - 1)
			y2 = ROWS - 1;
		for (int unsigned x = x1; x <= x2; x++)
			for (int unsigned y = y1; y <= y2; y++)
				plot_pixel(x, y, on);
	endfunction

	function automatic rsp_item_t next_stream_byte();
		rsp_item_t b;
		int unsigned col;
		b = '0;
		if (stream_slot == 0) begin
			b.out_byte = CMD_PAGE_BASE + 8'(stream_page);
		end else if (stream_slot == 1) begin
			b.out_byte = CMD_COL_LOW;
		end else if (stream_slot == 2) begin
			b.out_byte = CMD_COL_HIGH;
		end else begin
			col = stream_slot - CMD_SLOT_COUNT;
			b.out_byte = frame_bytes[col * PAGES + stream_page];
			b.is_data = 1'b1;
			b.last = (stream_page == PAGES - 1) && (col == SCREEN_W - 1);
		end
		stream_slot++;
		if (stream_slot == CMD_SLOT_COUNT + SCREEN_W) begin
			stream_slot = 0;
			stream_page = (stream_page + 1) % PAGES;
		end
		return b;
	endfunction

	function automatic void step_frame_model(cmd_item_t it);
		case (it.action)
			ACT_POINT: plot_pixel(it.x_start, it.y_start, it.pixel_value);
			ACT_FILL: fill_area(it.x_start, it.y_start, it.x_end, it.y_end, it.pixel_value);
			ACT_REFRESH: refresh_bytes_due.push_back(next_stream_byte());
			default: ;
		endcase
	endfunction

	function automatic cmd_item_t make_item(logic [1:0] action, logic [7:0] xs, logic [7:0] ys,
			logic [7:0] xe, logic [7:0] ye, logic pv);
		cmd_item_t it;
		it.action = action;
		it.x_start = xs;
		it.y_start = ys;
		it.x_end = xe;
		it.y_end = ye;
		it.pixel_value = pv;
		return it;
	endfunction

	function automatic cmd_item_t random_item();
		cmd_item_t it;
		int unsigned pick;
		pick = $urandom_range(99);
		it = make_item(ACT_REFRESH, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
			1'($urandom));
		if (pick < 20) begin
			it.action = ACT_POINT;
			if ($urandom_range(99) < 85) begin
				it.x_start = 8'($urandom_range(SCREEN_W - 1));
				it.y_start = 8'($urandom_range(ROWS - 1));
			end
		end else if (pick < 35) begin
			it.action = ACT_FILL;
			if ($urandom_range(99) < 90) begin
				it.x_start = 8'($urandom_range(SCREEN_W - 1));
				it.y_start = 8'($urandom_range(ROWS - 1));
				it.x_end = it.x_start + 8'($urandom_range(9));
				it.y_end = it.y_start + 8'($urandom_range(11));
			end
		end else if (pick >= 96) begin
			it.action = ACT_UNUSED;
		end
		return it;
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatch_count < 200)
			$display("ERROR at %0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic send_item(input cmd_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd <= it;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (!cmd_ready)
			@(posedge clk);
	endtask

	task automatic send_refreshes(input int n);
		repeat (n)
			send_item(make_item(ACT_REFRESH, 8'($urandom), 8'($urandom), 8'($urandom),
				8'($urandom), 1'($urandom)));
	endtask

	task automatic set_idle(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
	endtask

	task automatic test_edge_cases();
		send_item(make_item(ACT_POINT, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1));
		send_item(make_item(ACT_POINT, 8'd127, 8'd63, 8'd0, 8'd0, 1'b1));
		send_item(make_item(ACT_POINT, 8'd128, 8'd5, 8'd0, 8'd0, 1'b1));
		send_item(make_item(ACT_POINT, 8'd5, 8'd64, 8'd0, 8'd0, 1'b1));
		send_item(make_item(ACT_POINT, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1));
		send_item(make_item(ACT_FILL, 8'd9, 8'd3, 8'd2, 8'd10, 1'b1));
		send_item(make_item(ACT_FILL, 8'd2, 8'd10, 8'd5, 8'd3, 1'b1));
		send_item(make_item(ACT_FILL, 8'd120, 8'd56, 8'd255, 8'd255, 1'b1));
		send_item(make_item(ACT_FILL, 8'd200, 8'd0, 8'd255, 8'd10, 1'b1));
		send_item(make_item(ACT_FILL, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
		send_item(make_item(ACT_UNUSED, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1));
		send_refreshes(4);
		send_item(make_item(ACT_FILL, 8'd0, 8'd0, 8'd255, 8'd255, 1'b1));
		send_item(make_item(ACT_FILL, 8'd10, 8'd10, 8'd100, 8'd50, 1'b0));
		send_item(make_item(ACT_POINT, 8'd50, 8'd30, 8'd0, 8'd0, 1'b1));
		send_refreshes(4);
		send_item(make_item(ACT_POINT, 8'd1, 8'd63, 8'd0, 8'd0, 1'b0));
		send_item(make_item(ACT_POINT, 8'd126, 8'd0, 8'd0, 8'd0, 1'b0));
	endtask

	// Two pages' worth of refreshes in a row, so a page change inside the stream is seen.
	task automatic test_stream_run();
		send_refreshes(2 * PAGE_STREAM_LEN);
	endtask

	task automatic test_random_traffic(input int count);
		repeat (count)
			send_item(random_item());
	endtask

	always @(posedge clk) begin
		rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin : result_check
		rsp_item_t due;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (refresh_bytes_due.size() == 0) begin
					report_mismatch($sformatf("byte %02h arrived with none due", rsp.out_byte));
				end else begin
					due = refresh_bytes_due.pop_front();
					if (rsp.out_byte !== due.out_byte)
						report_mismatch($sformatf("out_byte %02h, should be %02h",
							rsp.out_byte, due.out_byte));
					if (rsp.is_data !== due.is_data)
						report_mismatch($sformatf("is_data %b, should be %b",
							rsp.is_data, due.is_data));
					if (rsp.last !== due.last)
						report_mismatch($sformatf("last %b, should be %b", rsp.last, due.last));
				end
			end
			if (cmd_valid && cmd_ready)
				step_frame_model(cmd);
			if ((rsp_valid && rsp_ready) || (cmd_valid && cmd_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= STALL_LIMIT) begin
					$display("Mismatches found");
					$finish;
				end
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		cmd_valid <= 1'b0;
		cmd <= '0;
		set_idle(14, 79);
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		test_edge_cases();
		test_stream_run();
		test_random_traffic(188);
		set_idle(79, 14);
		test_random_traffic(188);
		set_idle(0, 0);
		test_random_traffic(188);
		cmd_valid <= 1'b0;
		while (refresh_bytes_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/oledfb_pkg.sv
rtl/core/oledfb_front.sv
rtl/core/oledfb_fifo.sv
rtl/core/oledfb_back.sv
rtl/core/oled_framebuffer_draw_fill_refresh_top.sv
verif/testbench.sv
